FILE: hdl/dna_kmer_presence_counter_defines.svh
// Assertion shorthands shared by the RTL.
`ifndef DNA_KMER_PRESENCE_COUNTER_DEFINES_SVH
`define DNA_KMER_PRESENCE_COUNTER_DEFINES_SVH

// same-cycle implication
`define DKPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dkpc: implication check failed");

// next-cycle implication
`define DKPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dkpc: next-cycle check failed");

`endif

FILE: hdl/dkpc_pkg.sv
`timescale 1ns / 1ps
package dkpc_pkg;

  localparam int MAX_KMER_LEN_DEF    = 6;
  localparam int TABLE_ENTRIES_DEF   = 4096;
  localparam int SEQ_COUNT_WIDTH_DEF = 16;

  localparam int KMER_LEN_W    = 3;
  localparam int READ_INDEX_W  = 12;
  localparam int COUNT_W       = 32;
  localparam int KMER_IDX_W    = 16;
  localparam int SEQ_NUM_W     = 16;
  localparam int TRANS_ENTRIES = 16;
  localparam int TRANS_IDX_W   = 4;
  localparam int Q_DEPTH       = 2;

  localparam logic [KMER_LEN_W-1:0] KMER_LEN_RESET = 3'd6;

  localparam logic [2:0] BASE_A  = 3'd0;
  localparam logic [2:0] BASE_C  = 3'd1;
  localparam logic [2:0] BASE_G  = 3'd2;
  localparam logic [2:0] BASE_T  = 3'd3;
  localparam logic [2:0] NO_BASE = 3'd4;

  typedef enum logic [1:0] {
    OP_FEED     = 2'd0,
    OP_RD_KMER  = 2'd1,
    OP_RD_TRANS = 2'd2,
    OP_RD_TOTAL = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_EXEC  = 2'd2
  } bk_state_t;

  typedef struct packed {
    req_t                   op;
    logic                   kmer_hit;
    logic [KMER_IDX_W-1:0]  addr;
    logic                   trans_hit;
    logic [TRANS_IDX_W-1:0] trans_idx;
    logic [SEQ_NUM_W-1:0]   seq_num;
    logic                   wrap;
  } cmd_t;

  function automatic logic [2:0] base_code(input logic [7:0] ch);
    logic [2:0] code;
    case (ch)
      8'h41, 8'h61: code = BASE_A;
      8'h43, 8'h63: code = BASE_C;
      8'h47, 8'h67: code = BASE_G;
      8'h54, 8'h74: code = BASE_T;
      default:      code = NO_BASE;
    endcase
    return code;
  endfunction

endpackage

FILE: hdl/dkpc_front.sv
`timescale 1ns / 1ps
module dkpc_front #(
  parameter int MAX_KMER_LEN  = dkpc_pkg::MAX_KMER_LEN_DEF,
  parameter int TABLE_ENTRIES = dkpc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [dkpc_pkg::KMER_LEN_W-1:0]     cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_req_type,
  input  logic [7:0]                          in_base_char,
  input  logic                                in_seq_end,
  input  logic [dkpc_pkg::READ_INDEX_W-1:0]   in_read_index,
  input  logic                                q_full,
  input  logic                                bk_clearing,
  output logic                                push,
  output dkpc_pkg::cmd_t                      cmd
);
  import dkpc_pkg::*;

  localparam int WIN_W = 2 * MAX_KMER_LEN;
  localparam int RUN_W = $clog2(MAX_KMER_LEN + 1);

  logic [KMER_LEN_W-1:0] kmer_len_r;
  logic [WIN_W-1:0]      window_r, window_nxt;
  logic [RUN_W-1:0]      run_r, run_nxt;
  logic [2:0]            prev_r, prev_nxt;
  logic [SEQ_NUM_W-1:0]  seq_r, seq_nxt;

  logic                  accept;
  req_t                  req;
  logic [2:0]            code;
  logic [3:0]            k4;
  logic [WIN_W-1:0]      win_shift;
  logic [RUN_W-1:0]      run_inc;
  logic [KMER_IDX_W-1:0] kmask;
  logic [KMER_IDX_W-1:0] kidx;
  logic                  kin;

  assign in_stall = q_full | bk_clearing;
  assign accept   = in_valid & ~in_stall;
  assign push     = accept;
  assign req      = req_t'(in_req_type);
  assign code     = base_code(in_base_char);

  always_comb begin
    k4 = 4'(kmer_len_r);
    if (k4 == 4'd0) begin
      k4 = 4'd1;
    end else if (k4 > 4'(MAX_KMER_LEN)) begin
      k4 = 4'(MAX_KMER_LEN);
    end
    win_shift = WIN_W'({window_r, code[1:0]});
    run_inc   = (run_r < RUN_W'(MAX_KMER_LEN)) ? RUN_W'(run_r + 1'b1) : run_r;
    kmask     = ~({KMER_IDX_W{1'b1}} << {k4, 1'b0});
    kidx      = KMER_IDX_W'(win_shift) & kmask;
    kin       = (17'(kidx) < 17'(TABLE_ENTRIES));
  end

  always_comb begin
    window_nxt    = window_r;
    run_nxt       = run_r;
    prev_nxt      = prev_r;
    seq_nxt       = seq_r;
    cmd.op        = req;
    cmd.kmer_hit  = 1'b0;
    cmd.addr      = '0;
    cmd.trans_hit = 1'b0;
    cmd.trans_idx = '0;
    cmd.seq_num   = seq_r;
    cmd.wrap      = 1'b0;
    unique case (req)
      OP_FEED: begin
        if (code == NO_BASE) begin
          window_nxt = '0;
          run_nxt    = '0;
          prev_nxt   = NO_BASE;
        end else begin
          cmd.trans_hit = (prev_r != NO_BASE);
          cmd.trans_idx = {prev_r[1:0], code[1:0]};
          prev_nxt      = code;
          window_nxt    = win_shift;
          run_nxt       = run_inc;
          cmd.kmer_hit  = (4'(run_inc) >= k4) && kin;
          cmd.addr      = kidx;
        end
        if (in_seq_end) begin
          window_nxt = '0;
          run_nxt    = '0;
          prev_nxt   = NO_BASE;
          seq_nxt    = SEQ_NUM_W'(seq_r + 1'b1);
          cmd.wrap   = (seq_r == {SEQ_NUM_W{1'b1}});
        end
      end
      OP_RD_KMER: begin
        cmd.kmer_hit = (17'(in_read_index) < 17'(TABLE_ENTRIES));
        cmd.addr     = KMER_IDX_W'(in_read_index);
      end
      OP_RD_TRANS: begin
        cmd.trans_hit = (in_read_index < READ_INDEX_W'(TRANS_ENTRIES));
        cmd.trans_idx = in_read_index[TRANS_IDX_W-1:0];
      end
      OP_RD_TOTAL: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= KMER_LEN_RESET;
      window_r   <= '0;
      run_r      <= '0;
      prev_r     <= NO_BASE;
      seq_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        kmer_len_r <= cfg_wr_data;
      end
      if (accept) begin
        window_r <= window_nxt;
        run_r    <= run_nxt;
        prev_r   <= prev_nxt;
        seq_r    <= seq_nxt;
      end
    end
  end

endmodule

FILE: hdl/dkpc_fifo.sv
`timescale 1ns / 1ps
module dkpc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dkpc_pkg::cmd_t push_cmd,
  input  logic           pop,
  output dkpc_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import dkpc_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    priority if (push && !pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hdl/dkpc_back.sv
`timescale 1ns / 1ps
`include "dna_kmer_presence_counter_defines.svh"
module dkpc_back #(
  parameter int TABLE_ENTRIES   = dkpc_pkg::TABLE_ENTRIES_DEF,
  parameter int SEQ_COUNT_WIDTH = dkpc_pkg::SEQ_COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dkpc_pkg::cmd_t                 head,
  input  logic                           q_empty,
  output logic                           pop,
  output logic                           bk_clearing,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dkpc_pkg::COUNT_W-1:0]   out_count_value
);
  import dkpc_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_ENTRIES);
  localparam int TAG_W  = SEQ_NUM_W + 1;

  bk_state_t state_r, state_nxt;
  cmd_t      cmd_r;
  logic      clr_cnt_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic [TAG_W-1:0]           tag_mem [TABLE_ENTRIES];
  logic [SEQ_COUNT_WIDTH-1:0] cnt_mem [TABLE_ENTRIES];
  logic [TAG_W-1:0]           tag_rd_r;
  logic [SEQ_COUNT_WIDTH-1:0] cnt_rd_r;

  logic [COUNT_W-1:0] trans_r [TRANS_ENTRIES];
  logic [COUNT_W-1:0] total_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_value_r;

  logic                       clr_last;
  logic                       slot_free;
  logic [ADDR_W-1:0]          mem_addr;
  logic [TAG_W-1:0]           cur_tag;
  logic                       tag_we, cnt_we;
  logic [TAG_W-1:0]           tag_wdata;
  logic [SEQ_COUNT_WIDTH-1:0] cnt_wdata;
  logic                       out_load, trans_inc, total_inc;
  logic [COUNT_W-1:0]         trans_cur;
  logic [COUNT_W-1:0]         rd_value;

  assign clr_last        = (clr_addr_r == ADDR_W'(TABLE_ENTRIES - 1));
  assign slot_free       = ~out_valid_r | ~out_stall;
  assign cur_tag         = {1'b1, cmd_r.seq_num};
  assign trans_cur       = trans_r[cmd_r.trans_idx];
  assign bk_clearing     = (state_r == BK_CLEAR);
  assign out_valid       = out_valid_r;
  assign out_count_value = out_value_r;

  always_comb begin
    unique case (state_r)
      BK_CLEAR: mem_addr = clr_addr_r;
      BK_IDLE:  mem_addr = head.addr[ADDR_W-1:0];
      default:  mem_addr = cmd_r.addr[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd_r.op)
      OP_RD_KMER:  rd_value = cmd_r.kmer_hit ? COUNT_W'(cnt_rd_r) : '0;
      OP_RD_TRANS: rd_value = cmd_r.trans_hit ? trans_cur : '0;
      OP_RD_TOTAL: rd_value = total_r;
      default:     rd_value = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR: begin
        if (clr_last) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (cmd_r.op == OP_FEED) begin
          state_nxt = cmd_r.wrap ? BK_CLEAR : BK_IDLE;
        end else if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_CLEAR;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    tag_we    = 1'b0;
    cnt_we    = 1'b0;
    tag_wdata = '0;
    cnt_wdata = '0;
    out_load  = 1'b0;
    trans_inc = 1'b0;
    total_inc = 1'b0;
    unique case (state_r)
      BK_CLEAR: begin
        tag_we = 1'b1;
        cnt_we = clr_cnt_r;
      end
      BK_IDLE: begin
        pop = ~q_empty;
      end
      BK_EXEC: begin
        if (cmd_r.op == OP_FEED) begin
          total_inc = 1'b1;
          trans_inc = cmd_r.trans_hit;
          if (cmd_r.kmer_hit && (tag_rd_r != cur_tag)) begin
            tag_we    = 1'b1;
            tag_wdata = cur_tag;
            cnt_we    = 1'b1;
            cnt_wdata = (cnt_rd_r == {SEQ_COUNT_WIDTH{1'b1}}) ? cnt_rd_r
                                                              : cnt_rd_r + 1'b1;
          end
        end else begin
          out_load = slot_free;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tag_rd_r <= tag_mem[mem_addr];
    if (tag_we) begin
      tag_mem[mem_addr] <= tag_wdata;
    end
  end

  always_ff @(posedge clk) begin
    cnt_rd_r <= cnt_mem[mem_addr];
    if (cnt_we) begin
      cnt_mem[mem_addr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head;
    end
    if (out_load) begin
      out_value_r <= rd_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      for (int i = 0; i < TRANS_ENTRIES; i++) begin
        trans_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_CLEAR) begin
        clr_addr_r <= clr_last ? '0 : ADDR_W'(clr_addr_r + 1'b1);
        if (clr_last) begin
          clr_cnt_r <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (total_inc && (total_r != {COUNT_W{1'b1}})) begin
        total_r <= total_r + 1'b1;
      end
      if (trans_inc && (trans_cur != {COUNT_W{1'b1}})) begin
        trans_r[cmd_r.trans_idx] <= trans_cur + 1'b1;
      end
    end
  end

  `DKPC_ASSERT_IMP(a_pop_nonempty, pop, !q_empty)
  `DKPC_ASSERT_NXT(a_wrap_sweeps, (state_r == BK_EXEC) && (cmd_r.op == OP_FEED) && cmd_r.wrap, state_r == BK_CLEAR)
  `DKPC_ASSERT_IMP(a_load_free, out_load, !out_valid_r || !out_stall)
  `DKPC_ASSERT_IMP(a_idle_no_write, state_r == BK_IDLE, !tag_we && !cnt_we)

endmodule

FILE: hdl/dna_kmer_presence_counter.sv
// A read transaction passes through the command FIFO, cmd_r and out_value_r.
// The back end takes one transaction at a time (IDLE, then EXEC); a feed is a
// read-modify-write of the k-mer tag and count memories (read, then update).
// Reset (rst_n low, synchronous) clears all control state and counters, then a
// sweep of all TABLE_ENTRIES addresses zeroes the memories with in_stall high;
// a tag-only sweep of all addresses follows every 65536th sequence end.
`timescale 1ns / 1ps
module dna_kmer_presence_counter #(
  parameter int MAX_KMER_LEN    = dkpc_pkg::MAX_KMER_LEN_DEF,
  parameter int TABLE_ENTRIES   = dkpc_pkg::TABLE_ENTRIES_DEF,
  parameter int SEQ_COUNT_WIDTH = dkpc_pkg::SEQ_COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [dkpc_pkg::KMER_LEN_W-1:0]   cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_req_type,
  input  logic [7:0]                        in_base_char,
  input  logic                              in_seq_end,
  input  logic [dkpc_pkg::READ_INDEX_W-1:0] in_read_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dkpc_pkg::COUNT_W-1:0]      out_count_value
);
  import dkpc_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push, pop, q_full, q_empty, bk_clearing;

  dkpc_front #(
    .MAX_KMER_LEN  (MAX_KMER_LEN),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_base_char  (in_base_char),
    .in_seq_end    (in_seq_end),
    .in_read_index (in_read_index),
    .q_full        (q_full),
    .bk_clearing   (bk_clearing),
    .push          (push),
    .cmd           (push_cmd)
  );

  dkpc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  dkpc_back #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .SEQ_COUNT_WIDTH (SEQ_COUNT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_empty),
    .pop             (pop),
    .bk_clearing     (bk_clearing),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_count_value (out_count_value)
  );

endmodule
